// ===== hw/rtl/glyph_text_page_framebuffer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the glyph text page framebuffer
// Each macro expects clk and rst in scope; checks are off during reset.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_PAGE_FRAMEBUFFER_TOP_MACROS_SVH
`define GLYPH_TEXT_PAGE_FRAMEBUFFER_TOP_MACROS_SVH

// same-cycle implication
`define GTPF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GTPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gtpf_pkg.sv =====
// ----------------------------------------------------------------------------
// gtpf_pkg
// Shared constants, codes and payload types of the glyph text page framebuffer.
// ----------------------------------------------------------------------------
`default_nettype none

package gtpf_pkg;

  // frame store geometry
  localparam int WIDTH      = 128;
  localparam int PAGES      = 8;
  localparam int STORE_SIZE = WIDTH * PAGES;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int COL_W      = $clog2(WIDTH + 1);  // cursor may sit at WIDTH
  localparam int CCOL_W     = $clog2(WIDTH);      // clamped column
  localparam int PG_W       = (PAGES > 1) ? $clog2(PAGES) : 1;

  // character cell
  localparam int GLYPH_COLS = 5;
  localparam int CELL_COLS  = 6;
  localparam int STEP_W     = $clog2(CELL_COLS);

  // glyph ROM layout
  localparam int GLYPHS  = 41;
  localparam int GLYPH_W = $clog2(GLYPHS);
  localparam logic [GLYPH_W-1:0] G_BLANK    = GLYPH_W'(0);
  localparam logic [GLYPH_W-1:0] G_DIGIT    = GLYPH_W'(1);
  localparam logic [GLYPH_W-1:0] G_LETTER   = GLYPH_W'(11);
  localparam logic [GLYPH_W-1:0] G_COLON    = GLYPH_W'(37);
  localparam logic [GLYPH_W-1:0] G_DASH     = GLYPH_W'(38);
  localparam logic [GLYPH_W-1:0] G_DOT      = GLYPH_W'(39);
  localparam logic [GLYPH_W-1:0] G_QUESTION = GLYPH_W'(40);

  // command queue between front and back
  localparam int QDEPTH = 2;  // power of two
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_CURSOR = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [7:0] target_column;
    logic [7:0] target_page;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] cursor_column;
    logic [2:0] cursor_page;
  } out_t;

  // decoded command
  typedef struct packed {
    func_t              op;
    logic [GLYPH_W-1:0] glyph;
    logic [CCOL_W-1:0]  col;
    logic [PG_W-1:0]    page;
  } cmd_t;

  // queue head offered to the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } op_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/glyph_text_page_framebuffer_top.sv =====
// ----------------------------------------------------------------------------
// glyph_text_page_framebuffer_top
// 5x7 text engine over a page-organized monochrome frame store.
// ----------------------------------------------------------------------------
// Input queue: drive cmd and raise push; the item is taken on a clock edge
// where push is high and full is low. A two-entry command queue decouples
// the decoder from the executer, so a few items can be pushed while one runs.
// Result register: while empty is low, result holds the pending result; raise pop
// to take it. Every item yields exactly one result, in order.
// Work per item at the executer (the frame store has one port): set cursor
//   updates the cursor, read fetches one store byte, write character stores
//   five glyph bytes and a spacer; clear zeroes the store, one byte per cycle.
// A result is registered when its command is taken; a read's, in ST_READ.
// Reset: cursor homes and a sweep zeroes all 1024 store bytes; items
// can be pushed into the queue meanwhile but none execute until it ends.
// A stalled receiver holds the result register; the executer then waits
// with the next command until the result is taken, and the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_text_page_framebuffer_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire gtpf_pkg::in_t  cmd,
  output logic                empty,
  input  wire logic           pop,
  output gtpf_pkg::out_t      result
);

  gtpf_pkg::op_req_t req;
  logic              take;

  gtpf_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .cmd  (cmd),
    .req  (req),
    .take (take)
  );

  gtpf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .take   (take),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/gtpf_front.sv =====
// ----------------------------------------------------------------------------
// gtpf_front
// Accepts items, decodes glyph and clamps targets, queues decoded commands.
// ----------------------------------------------------------------------------
`default_nettype none

module gtpf_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire gtpf_pkg::in_t    cmd,
  output gtpf_pkg::op_req_t     req,
  input  wire logic             take
);

  function automatic logic [gtpf_pkg::GLYPH_W-1:0] glyph_index(input logic [7:0] code);
    logic [gtpf_pkg::GLYPH_W-1:0] g;
    g = gtpf_pkg::G_QUESTION;
    if (code == 8'h20) begin
      g = gtpf_pkg::G_BLANK;
    end else if (code >= 8'h30 && code <= 8'h39) begin
      g = gtpf_pkg::G_DIGIT + gtpf_pkg::GLYPH_W'(code - 8'h30);
    end else if (code >= 8'h41 && code <= 8'h5A) begin
      g = gtpf_pkg::G_LETTER + gtpf_pkg::GLYPH_W'(code - 8'h41);
    end else if (code == 8'h3A) begin
      g = gtpf_pkg::G_COLON;
    end else if (code == 8'h2D) begin
      g = gtpf_pkg::G_DASH;
    end else if (code == 8'h2E) begin
      g = gtpf_pkg::G_DOT;
    end
    return g;
  endfunction

  gtpf_pkg::cmd_t dec;
  gtpf_pkg::cmd_t q [gtpf_pkg::QDEPTH];
  logic [gtpf_pkg::QPTR_W-1:0] wr_ptr;
  logic [gtpf_pkg::QPTR_W-1:0] rd_ptr;
  logic [gtpf_pkg::QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  always_comb begin
    dec.op    = gtpf_pkg::func_t'(cmd.func);
    dec.glyph = glyph_index(cmd.char_code);
    dec.col   = (cmd.target_column < 8'(gtpf_pkg::WIDTH)) ?
                gtpf_pkg::CCOL_W'(cmd.target_column) : gtpf_pkg::CCOL_W'(gtpf_pkg::WIDTH - 1);
    dec.page  = (cmd.target_page < 8'(gtpf_pkg::PAGES)) ?
                gtpf_pkg::PG_W'(cmd.target_page) : gtpf_pkg::PG_W'(gtpf_pkg::PAGES - 1);
  end

  assign full      = (count == gtpf_pkg::QCNT_W'(gtpf_pkg::QDEPTH));
  assign do_push   = push && !full;
  assign req.valid = (count != '0);
  assign req.cmd   = q[rd_ptr];
  assign do_pop    = req.valid && take;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + gtpf_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + gtpf_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + gtpf_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - gtpf_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gtpf_back.sv =====
// ----------------------------------------------------------------------------
// gtpf_back
// Executes decoded commands against the frame store and holds the cursor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "glyph_text_page_framebuffer_top_macros.svh"

module gtpf_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gtpf_pkg::op_req_t req,
  output logic                   take,
  output logic                   empty,
  input  wire logic              pop,
  output gtpf_pkg::out_t         result
);

  // columns packed left to right, leftmost column in the top byte
  localparam logic [39:0] FONT [gtpf_pkg::GLYPHS] = '{
    40'h0000000000,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100, 40'h2040413F01,
    40'h7F08142241, 40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F,
    40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h7F2018207F, 40'h6314081463, 40'h0708700807, 40'h6151494543,
    40'h0036360000,
    40'h0808080808,
    40'h0060600000,
    40'h0201510906
  };

  function automatic logic [7:0] font_byte(input logic [gtpf_pkg::GLYPH_W-1:0] g,
                                           input logic [gtpf_pkg::STEP_W-1:0] step);
    logic [39:0] row;
    logic [7:0]  b;
    row = FONT[g];
    case (step)
      gtpf_pkg::STEP_W'(0): b = row[39:32];
      gtpf_pkg::STEP_W'(1): b = row[31:24];
      gtpf_pkg::STEP_W'(2): b = row[23:16];
      gtpf_pkg::STEP_W'(3): b = row[15:8];
      gtpf_pkg::STEP_W'(4): b = row[7:0];
      default:              b = 8'h00;  // spacer column
    endcase
    return b;
  endfunction

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_READ  = 4'b1000
  } state_t;

  state_t state;
  logic [gtpf_pkg::ADDR_W-1:0]  sweep;
  logic [gtpf_pkg::ADDR_W-1:0]  wr_addr;
  logic [gtpf_pkg::GLYPH_W-1:0] wr_glyph;
  logic [gtpf_pkg::STEP_W-1:0]  wr_step;
  logic [gtpf_pkg::COL_W-1:0]   cur_col;
  logic [gtpf_pkg::PG_W-1:0]    cur_pg;
  logic                         out_valid;
  gtpf_pkg::out_t               out_item;

  logic [7:0] mem [gtpf_pkg::STORE_SIZE];
  logic [7:0] rd_data;
  logic                        mem_we;
  logic [gtpf_pkg::ADDR_W-1:0] mem_addr;
  logic [7:0]                  mem_wdata;

  logic                        slot_free;
  logic                        wrap;
  logic [gtpf_pkg::COL_W-1:0]  wcol;
  logic [gtpf_pkg::PG_W-1:0]   wpg;
  logic [gtpf_pkg::PG_W-1:0]   pg_inc;
  logic [gtpf_pkg::ADDR_W-1:0] wbase;
  logic [gtpf_pkg::ADDR_W-1:0] rd_addr;

  assign slot_free = !out_valid || pop;
  assign take      = (state == ST_IDLE) && req.valid && slot_free;
  assign empty     = !out_valid;
  assign result    = out_item;

  // wrap to the next page when the cell would not fit
  always_comb begin
    wrap    = cur_col > gtpf_pkg::COL_W'(gtpf_pkg::WIDTH - gtpf_pkg::CELL_COLS);
    pg_inc  = (cur_pg == gtpf_pkg::PG_W'(gtpf_pkg::PAGES - 1)) ?
              '0 : cur_pg + gtpf_pkg::PG_W'(1);
    wcol    = wrap ? '0 : cur_col;
    wpg     = wrap ? pg_inc : cur_pg;
    wbase   = gtpf_pkg::ADDR_W'(wpg) * gtpf_pkg::ADDR_W'(gtpf_pkg::WIDTH)
            + gtpf_pkg::ADDR_W'(wcol);
    rd_addr = gtpf_pkg::ADDR_W'(req.cmd.page) * gtpf_pkg::ADDR_W'(gtpf_pkg::WIDTH)
            + gtpf_pkg::ADDR_W'(req.cmd.col);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = rd_addr;
    mem_wdata = 8'h00;
    unique case (state) inside
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = sweep;
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_addr  = wr_addr;
        mem_wdata = font_byte(wr_glyph, wr_step);
      end
      ST_IDLE, ST_READ: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      cur_col   <= '0;
      cur_pg    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          sweep <= sweep + gtpf_pkg::ADDR_W'(1);
          if (sweep == gtpf_pkg::ADDR_W'(gtpf_pkg::STORE_SIZE - 1)) begin
            sweep <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            unique case (req.cmd.op)
              gtpf_pkg::FUNC_WRITE: begin
                cur_col   <= wcol + gtpf_pkg::COL_W'(gtpf_pkg::CELL_COLS);
                cur_pg    <= wpg;
                out_valid <= 1'b1;
                wr_addr   <= wbase;
                wr_glyph  <= req.cmd.glyph;
                wr_step   <= '0;
                state     <= ST_WRITE;
              end
              gtpf_pkg::FUNC_CURSOR: begin
                cur_col   <= gtpf_pkg::COL_W'(req.cmd.col);
                cur_pg    <= req.cmd.page;
                out_valid <= 1'b1;
              end
              gtpf_pkg::FUNC_CLEAR: begin
                cur_col   <= '0;
                cur_pg    <= '0;
                out_valid <= 1'b1;
                state     <= ST_CLEAR;
              end
              gtpf_pkg::FUNC_READ: begin
                state <= ST_READ;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_WRITE: begin
          wr_addr <= wr_addr + gtpf_pkg::ADDR_W'(1);
          wr_step <= wr_step + gtpf_pkg::STEP_W'(1);
          if (wr_step == gtpf_pkg::STEP_W'(gtpf_pkg::CELL_COLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload; cursor already reflects the operation
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      out_item.read_data     <= rd_data;
      out_item.cursor_column <= 8'(cur_col);
      out_item.cursor_page   <= 3'(cur_pg);
    end else if (take) begin
      out_item.read_data <= 8'h00;
      unique case (req.cmd.op) inside
        gtpf_pkg::FUNC_WRITE: begin
          out_item.cursor_column <= 8'(wcol + gtpf_pkg::COL_W'(gtpf_pkg::CELL_COLS));
          out_item.cursor_page   <= 3'(wpg);
        end
        gtpf_pkg::FUNC_CURSOR: begin
          out_item.cursor_column <= 8'(req.cmd.col);
          out_item.cursor_page   <= 3'(req.cmd.page);
        end
        gtpf_pkg::FUNC_CLEAR, gtpf_pkg::FUNC_READ: begin
          out_item.cursor_column <= 8'h00;
          out_item.cursor_page   <= 3'd0;
        end
        default: begin
          out_item.cursor_column <= 8'h00;
          out_item.cursor_page   <= 3'd0;
        end
      endcase
    end
  end

  `GTPF_ASSERT_IMPLY(a_col_range, 1'b1, cur_col <= gtpf_pkg::COL_W'(gtpf_pkg::WIDTH), "cursor column past width")
  `GTPF_ASSERT_IMPLY(a_step_range, state == ST_WRITE, wr_step < gtpf_pkg::STEP_W'(gtpf_pkg::CELL_COLS), "glyph step overrun")
  `GTPF_ASSERT_NEXT(a_read_slot, take && req.cmd.op == gtpf_pkg::FUNC_READ, !out_valid && state == ST_READ, "read issued without free result slot")
  `GTPF_ASSERT_NEXT(a_write_fits, take && req.cmd.op == gtpf_pkg::FUNC_WRITE, cur_col <= gtpf_pkg::COL_W'(gtpf_pkg::WIDTH) && cur_col >= gtpf_pkg::COL_W'(gtpf_pkg::CELL_COLS), "cell crosses page edge")

endmodule

`default_nettype wire
